// File: src/dpfc_pkg.sv
package dpfc_pkg;

  localparam int MODE_W      = 3;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 2;

  localparam logic [MODE_W-1:0] MODE_ASIS   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP16 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RGB444 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RGB332 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GRAY8  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GRAY4  = 3'd5;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       source_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // One accepted item's worth of result bytes, in transmit order.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            cnt_m1;
    logic                        data_valid;
    logic                        last;
  } job_t;

  function automatic logic [15:0] rgb332_pixel(input logic [7:0] v);
    logic [2:0] r;
    logic [2:0] g;
    logic [1:0] b;
    logic [4:0] b5;
    r  = v[7:5];
    g  = v[4:2];
    b  = v[1:0];
    b5 = {b, 3'b000} | {2'b00, b, 1'b0} | {4'b0000, b[1]};
    // red: r3 in the top bits, bit 1 stays clear, r3 msb lands in bit 0
    return {r, 1'b0, r[2], g, g, b5};
  endfunction

  function automatic logic [15:0] gray8_pixel(input logic [7:0] v);
    return {v[7:3], v[7:2], v[7:3]};
  endfunction

  function automatic logic [15:0] gray4_pixel(input logic [3:0] n);
    logic [5:0] g6;
    logic [4:0] g5;
    g6 = {n, n[3:2]};
    g5 = g6[5:1];
    return {g5, g6, g5};
  endfunction

endpackage

// File: src/dpfc_front.sv
module dpfc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [dpfc_pkg::MODE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dpfc_pkg::in_item_t            in_data,
  input  logic                          q_full,
  output logic                          push,
  output dpfc_pkg::job_t                job
);

  logic [dpfc_pkg::MODE_W-1:0] mode_r;
  logic [7:0]                  held_byte_r;
  logic                        byte_phase_r;
  logic                        pixel_phase_r;
  logic [3:0]                  held_blue_r;

  logic       accept;
  logic       has_res;
  logic       hold_byte;
  logic       hold_blue;
  logic [7:0] v;
  logic       last;
  logic [3:0] r4;
  logic [3:0] g4;
  logic [3:0] b4;
  logic [15:0] pix_a;
  logic [15:0] pix_b;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && has_res;
  assign v        = in_data.source_byte;
  assign last     = in_data.source_last;

  // RGB565 little endian: held byte is low, current byte is high
  assign r4 = v[7:4];
  assign g4 = {v[2:0], held_byte_r[7]};
  assign b4 = held_byte_r[4:1];

  always_comb begin
    has_res        = 1'b1;
    hold_byte      = 1'b0;
    hold_blue      = 1'b0;
    job.bytes      = '0;
    job.cnt_m1     = '0;
    job.data_valid = 1'b1;
    job.last       = last;
    pix_a          = '0;
    pix_b          = '0;
    case (mode_r)
      dpfc_pkg::MODE_SWAP16: begin
        if (!byte_phase_r) begin
          job.bytes[0] = v;
          if (!last) begin
            has_res   = 1'b0;
            hold_byte = 1'b1;
          end
        end else begin
          job.bytes[0] = v;
          job.bytes[1] = held_byte_r;
          job.cnt_m1   = 2'd1;
        end
      end
      dpfc_pkg::MODE_RGB444: begin
        if (!byte_phase_r) begin
          if (!last) begin
            has_res   = 1'b0;
            hold_byte = 1'b1;
          end else if (pixel_phase_r) begin
            job.bytes[0] = {held_blue_r, 4'h0};
          end else begin
            // empty end marker
            job.data_valid = 1'b0;
          end
        end else if (!pixel_phase_r) begin
          job.bytes[0] = {r4, g4};
          if (last) begin
            job.bytes[1] = {b4, 4'h0};
            job.cnt_m1   = 2'd1;
          end else begin
            hold_blue = 1'b1;
          end
        end else begin
          job.bytes[0] = {held_blue_r, r4};
          job.bytes[1] = {g4, b4};
          job.cnt_m1   = 2'd1;
        end
      end
      dpfc_pkg::MODE_RGB332: begin
        pix_a        = dpfc_pkg::rgb332_pixel(v);
        job.bytes[0] = pix_a[15:8];
        job.bytes[1] = pix_a[7:0];
        job.cnt_m1   = 2'd1;
      end
      dpfc_pkg::MODE_GRAY8: begin
        pix_a        = dpfc_pkg::gray8_pixel(v);
        job.bytes[0] = pix_a[15:8];
        job.bytes[1] = pix_a[7:0];
        job.cnt_m1   = 2'd1;
      end
      dpfc_pkg::MODE_GRAY4: begin
        pix_a        = dpfc_pkg::gray4_pixel(v[7:4]);
        pix_b        = dpfc_pkg::gray4_pixel(v[3:0]);
        job.bytes[0] = pix_a[15:8];
        job.bytes[1] = pix_a[7:0];
        job.bytes[2] = pix_b[15:8];
        job.bytes[3] = pix_b[7:0];
        job.cnt_m1   = 2'd3;
      end
      default: begin
        job.bytes[0] = v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= dpfc_pkg::MODE_ASIS;
      byte_phase_r  <= 1'b0;
      pixel_phase_r <= 1'b0;
      held_byte_r   <= '0;
      held_blue_r   <= '0;
    end else if (cfg_valid) begin
      // mode change drops any partial word or pixel
      mode_r        <= cfg_data;
      byte_phase_r  <= 1'b0;
      pixel_phase_r <= 1'b0;
    end else if (accept) begin
      if (hold_byte) begin
        held_byte_r  <= v;
        byte_phase_r <= 1'b1;
      end else if (mode_r == dpfc_pkg::MODE_SWAP16 || mode_r == dpfc_pkg::MODE_RGB444) begin
        byte_phase_r <= 1'b0;
      end
      if (hold_blue) begin
        held_blue_r   <= b4;
        pixel_phase_r <= 1'b1;
      end else if (mode_r == dpfc_pkg::MODE_RGB444 && byte_phase_r) begin
        pixel_phase_r <= 1'b0;
      end
      if (last) begin
        byte_phase_r  <= 1'b0;
        pixel_phase_r <= 1'b0;
      end
    end
  end

endmodule

// File: src/dpfc_queue.sv
module dpfc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dpfc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dpfc_pkg::job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dpfc_pkg::job_t       slots_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: src/dpfc_back.sv
module dpfc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  dpfc_pkg::job_t      q_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output dpfc_pkg::out_item_t out_data
);

  dpfc_pkg::job_t                job_r;
  logic [dpfc_pkg::CNT_W-1:0]    idx_r;
  logic                          busy_r;
  logic                          out_valid_r;
  dpfc_pkg::out_item_t           out_data_r;

  logic load_ok;
  logic advance;
  logic at_end;
  logic done;

  assign load_ok = !out_valid_r || !out_stall;
  assign advance = busy_r && load_ok;
  assign at_end  = (idx_r == job_r.cnt_m1);
  assign done    = advance && at_end;
  // refill the working register on the cycle its last byte goes out
  assign pop     = q_valid && (!busy_r || done);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.out_byte  <= job_r.bytes[idx_r];
      out_data_r.out_valid <= job_r.data_valid;
      out_data_r.out_last  <= job_r.last && at_end;
    end
  end

endmodule

// File: src/display_pixel_format_converter_top.sv
// Display pixel format converter: turns a display byte stream into one of six
// forms picked by the mode register (as-is, swap16, RGB565LE to RGB444, or
// RGB332 / gray8 / gray4 expanded to big-endian RGB565).
// Input channel in_valid/in_stall/in_data carries one source byte and its
// frame-end flag per transfer. Output channel out_valid/out_stall/out_data
// carries one result byte per transfer; out_data.out_valid low marks an empty
// end marker. The user must write the mode (cfg_valid/cfg_ready/cfg_data) only
// while the block is idle; the block does not enforce this. A write drops any
// partial word or pixel. Items pass the queue, then the working register, then
// the output register. Throughput: one result byte per cycle while out_stall
// is low, set by the single-byte output register; an item gives 1 (as-is),
// 0 to 2 (swap16, RGB444), 2 (RGB332, gray8) or 4 (gray4) result bytes.
// A front stage classifies and converts items into jobs, a queue of
// QUEUE_DEPTH jobs decouples it from the byte serializer at the back.
// Synchronous reset clears mode to as-is and drops all pending data. When the
// receiver stalls, the output holds and the queue fills; in_stall rises once
// the queue is full.
module display_pixel_format_converter_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dpfc_pkg::MODE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dpfc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dpfc_pkg::out_item_t           out_data
);

  logic           q_full;
  logic           push;
  dpfc_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  dpfc_pkg::job_t head_job;

  assign cfg_ready = 1'b1;

  dpfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  dpfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  dpfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_job     (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/display_pixel_format_converter_top_tb.sv
module display_pixel_format_converter_top_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 42;

  typedef enum logic [1:0] {OP_BYTE, OP_MODE, OP_SETTLE} stim_kind_t;

  typedef struct {
    stim_kind_t                  kind;
    dpfc_pkg::in_item_t          item;
    logic [dpfc_pkg::MODE_W-1:0] mode;
    int                          send_pct;
    int                          recv_pct;
  } stim_op_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dpfc_pkg::MODE_W-1:0]   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  dpfc_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  dpfc_pkg::out_item_t           out_data;

  display_pixel_format_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  stim_op_t            stim_ops[$];
  dpfc_pkg::out_item_t converted_bytes[$];
  int                  errors = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  bit                  in_taken = 1'b0;
  bit                  cfg_taken = 1'b0;

  // predictor state, reset values
  logic [dpfc_pkg::MODE_W-1:0] conv_mode = dpfc_pkg::MODE_ASIS;
  logic [7:0]                  held_first = '0;
  logic                        word_half = 1'b0;
  logic                        pixel_odd = 1'b0;
  logic [3:0]                  held_blue_nib = '0;

  function automatic void emit(logic [7:0] b, logic v, logic l);
    dpfc_pkg::out_item_t r;
    r.out_byte  = b;
    r.out_valid = v;
    r.out_last  = l;
    converted_bytes.push_back(r);
  endfunction

  function automatic void emit_pixel(logic [15:0] pix, logic l);
    emit(pix[15:8], 1'b1, 1'b0);
    emit(pix[7:0], 1'b1, l);
  endfunction

  function automatic logic [15:0] gray4_expand(logic [3:0] n);
    logic [5:0] g6;
    logic [4:0] g5;
    g6 = {n, n[3:2]};
    g5 = g6[5:1];
    return {g5, g6, g5};
  endfunction

  function automatic void convert_source_byte(dpfc_pkg::in_item_t it);
    logic [7:0]  v;
    logic        l;
    logic [15:0] pix;
    logic [3:0]  r;
    logic [3:0]  g;
    logic [3:0]  b;
    v = it.source_byte;
    l = it.source_last;
    case (conv_mode)
      dpfc_pkg::MODE_SWAP16: begin
        if (!word_half) begin
          if (l) begin
            emit(v, 1'b1, 1'b1);
          end else begin
            held_first = v;
            word_half  = 1'b1;
          end
        end else begin
          emit(v, 1'b1, 1'b0);
          emit(held_first, 1'b1, l);
          word_half = 1'b0;
        end
      end
      dpfc_pkg::MODE_RGB444: begin
        if (!word_half) begin
          if (l) begin
            // lone trailing byte is dropped; flush a pending blue or mark the end
            if (pixel_odd) emit({held_blue_nib, 4'h0}, 1'b1, 1'b1);
            else emit(8'h00, 1'b0, 1'b1);
          end else begin
            held_first = v;
            word_half  = 1'b1;
          end
        end else begin
          pix = {v, held_first};
          r = pix[15:12];
          g = pix[10:7];
          b = pix[4:1];
          word_half = 1'b0;
          if (!pixel_odd) begin
            emit({r, g}, 1'b1, 1'b0);
            if (l) begin
              emit({b, 4'h0}, 1'b1, 1'b1);
            end else begin
              held_blue_nib = b;
              pixel_odd     = 1'b1;
            end
          end else begin
            emit({held_blue_nib, r}, 1'b1, 1'b0);
            emit({g, b}, 1'b1, l);
            pixel_odd = 1'b0;
          end
        end
      end
      dpfc_pkg::MODE_RGB332: begin
        pix = {v[7:5], 1'b0, v[7], v[4:2], v[4:2], v[1:0], v[1:0], v[1]};
        emit_pixel(pix, l);
      end
      dpfc_pkg::MODE_GRAY8: emit_pixel({v[7:3], v[7:2], v[7:3]}, l);
      dpfc_pkg::MODE_GRAY4: begin
        emit_pixel(gray4_expand(v[7:4]), 1'b0);
        emit_pixel(gray4_expand(v[3:0]), l);
      end
      default: emit(v, 1'b1, l);
    endcase
    if (l) begin
      word_half = 1'b0;
      pixel_odd = 1'b0;
    end
  endfunction

  // transfers are observed at the rising edge
  always @(posedge clk) begin
    dpfc_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        convert_source_byte(in_data);
        void'(stim_ops.pop_front());
        in_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        conv_mode = cfg_data;
        word_half = 1'b0;
        pixel_odd = 1'b0;
        void'(stim_ops.pop_front());
        cfg_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (converted_bytes.size() == 0) begin
          $error("result with nothing expected: byte %h valid %b last %b",
                 out_data.out_byte, out_data.out_valid, out_data.out_last);
          errors++;
        end else begin
          want = converted_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.out_valid !== want.out_valid) begin
            $error("out_valid: expected %b, got %b", want.out_valid, out_data.out_valid);
            errors++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || converted_bytes.size() != 0)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // driver: all inputs change at the falling edge
  always @(negedge clk) begin
    logic                        nv_in;
    logic                        nv_cfg;
    dpfc_pkg::in_item_t          nd;
    logic [dpfc_pkg::MODE_W-1:0] nm;
    if (rst_n) begin
      nv_in  = in_valid && !in_taken;
      nv_cfg = cfg_valid && !cfg_taken;
      nd     = in_data;
      nm     = cfg_data;
      in_taken  = 1'b0;
      cfg_taken = 1'b0;
      if (!nv_in && !nv_cfg && stim_ops.size() > 0) begin
        case (stim_ops[0].kind)
          OP_BYTE: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              nv_in = 1'b1;
              nd    = stim_ops[0].item;
            end
          end
          OP_MODE: begin
            // mode changes only once the block has gone quiet
            if (converted_bytes.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              nv_cfg = 1'b1;
              nm     = stim_ops[0].mode;
            end
          end
          default: begin
            if (converted_bytes.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              send_idle_pct = stim_ops[0].send_pct;
              recv_idle_pct = stim_ops[0].recv_pct;
              void'(stim_ops.pop_front());
            end
          end
        endcase
      end
      in_valid  <= nv_in;
      in_data   <= nd;
      cfg_valid <= nv_cfg;
      cfg_data  <= nm;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void push_byte(logic [7:0] b, logic l);
    stim_op_t op;
    op.kind = OP_BYTE;
    op.item.source_byte = b;
    op.item.source_last = l;
    op.mode = '0;
    op.send_pct = 0;
    op.recv_pct = 0;
    stim_ops.push_back(op);
  endfunction

  function automatic void push_mode(logic [dpfc_pkg::MODE_W-1:0] m);
    stim_op_t op;
    op.kind = OP_MODE;
    op.item = '0;
    op.mode = m;
    op.send_pct = 0;
    op.recv_pct = 0;
    stim_ops.push_back(op);
  endfunction

  function automatic void push_settle(int sp, int rp);
    stim_op_t op;
    op.kind = OP_SETTLE;
    op.item = '0;
    op.mode = '0;
    op.send_pct = sp;
    op.recv_pct = rp;
    stim_ops.push_back(op);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int                          sp;
    int                          rp;
    int                          made;
    int                          len;
    logic [dpfc_pkg::MODE_W-1:0] cur;
    bit                          broken;
    bit                          need_mode;

    // directed: extremes, every mode, trailing-byte repairs, mid-word mode change
    push_settle(36, 59);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_mode(dpfc_pkg::MODE_SWAP16);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'hAB, 1'b1);
    push_byte(8'h55, 1'b0);
    push_mode(dpfc_pkg::MODE_RGB444);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'hCD, 1'b0);
    push_byte(8'hAB, 1'b0);
    push_byte(8'h77, 1'b1);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b1);
    push_mode(dpfc_pkg::MODE_RGB332);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_mode(dpfc_pkg::MODE_GRAY8);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_mode(dpfc_pkg::MODE_GRAY4);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h5A, 1'b1);

    cur       = dpfc_pkg::MODE_GRAY4;
    need_mode = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      sp = (ph == 0) ? 36 : (ph == 1) ? 59 : 0;
      rp = (ph == 0) ? 59 : (ph == 1) ? 36 : 0;
      push_settle(sp, rp);
      made = 0;
      while (made < PHASE_ITEMS) begin
        if (need_mode || $urandom_range(1) == 0) begin
          cur = dpfc_pkg::MODE_W'($urandom_range(dpfc_pkg::MODE_GRAY4));
          push_mode(cur);
        end
        len = $urandom_range(1, 10);
        // most swap16 / RGB444 frames carry whole words
        if ((cur == dpfc_pkg::MODE_SWAP16 || cur == dpfc_pkg::MODE_RGB444) &&
            $urandom_range(9) < 8)
          len = (len < 2) ? 2 : (len & ~1);
        broken    = ($urandom_range(9) == 0);
        need_mode = broken;
        for (int i = 0; i < len; i++)
          push_byte(pick_byte(), !broken && i == len - 1);
        made += len;
        if ($urandom_range(7) == 0) push_settle(sp, rp);
      end
    end
    // make sure the stream ends on a closed frame
    push_byte(pick_byte(), 1'b1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_ops.size() > 0 || converted_bytes.size() > 0 ||
           quiet_cycles < SETTLE_CYCLES)
      @(posedge clk);

    if (errors == 0)
      $display("** display_pixel_format_converter_top: PASSED **");
    else
      $display("** display_pixel_format_converter_top: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** display_pixel_format_converter_top: FAILED **");
    $finish;
  end

endmodule
